// File: rtl/ocpp_pkg.sv
// Package with the types, constants and tables of the omnidirectional camera projection block.
`timescale 1ns / 1ps
`default_nettype none
package ocpp_pkg;

  localparam int MAX_TERMS = 16;
  localparam int TERM_W = $clog2(MAX_TERMS);
  localparam int TCNT_W = 6;

  localparam logic signed [47:0] HI48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] LO48 = 48'sh8000_0000_0000;
  localparam logic signed [31:0] AFFINE_C_RESET = 32'sh4000_0000;

  typedef enum logic [2:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_AFFINE_C = 3'd2,
    CFG_AFFINE_D = 3'd3,
    CFG_AFFINE_E = 3'd4,
    CFG_POLY_TERMS = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_PROJECT = 1'b1
  } func_e;

  typedef struct packed {
    logic [27:0] center_x;
    logic [27:0] center_y;
    logic signed [31:0] affine_c;
    logic signed [31:0] affine_d;
    logic signed [31:0] affine_e;
    logic [4:0] poly_terms;
  } cfg_t;

  typedef struct packed {
    logic func;
    logic [3:0] coef_index;
    logic signed [47:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic on_axis;
  } out_rsp_t;

  typedef struct packed {
    logic start;
    logic signed [47:0] a;
    logic signed [31:0] b;
    logic sh38;
    logic sat;
  } mul_req_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] t;
    case (i)
      5'd0: t = 32'sd843314857;
      5'd1: t = 32'sd497837829;
      5'd2: t = 32'sd263043837;
      5'd3: t = 32'sd133525159;
      5'd4: t = 32'sd67021687;
      5'd5: t = 32'sd33543516;
      5'd6: t = 32'sd16775851;
      5'd7: t = 32'sd8388437;
      5'd8: t = 32'sd4194283;
      5'd9: t = 32'sd2097149;
      5'd10: t = 32'sd1048576;
      default: t = 32'sd1 <<< (5'd30 - i);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ocpp_mul.sv
// Shared multi-cycle signed multiplier with rounding shift and optional 48-bit clamp.
`timescale 1ns / 1ps
`default_nettype none
module ocpp_mul import ocpp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mul_req_t            req_i,
  output logic                done_o,
  output logic signed [48:0]  res_o
);

  logic        busy_q;
  logic [1:0]  cnt_q;
  logic [47:0] a_q;
  logic [31:0] b_q;
  logic        neg_q, sh38_q, sat_q;
  logic [79:0] acc_q;
  logic        done_q;
  logic signed [48:0] res_q;

  logic [47:0] pp;
  logic [80:0] rsum;
  logic [80:0] shd;
  logic [47:0] rmag;

  assign pp   = a_q[{cnt_q, 4'b0} +: 16] * b_q;
  assign rsum = {1'b0, acc_q} + (sh38_q ? (81'd1 << 37) : (81'd1 << 29));
  assign shd  = sh38_q ? (rsum >> 38) : (rsum >> 30);
  assign rmag = (sat_q && (shd > 81'(HI48))) ? HI48 : shd[47:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      neg_q  <= 1'b0;
      sh38_q <= 1'b0;
      sat_q  <= 1'b0;
      acc_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        acc_q  <= '0;
        a_q    <= req_i.a[47] ? 48'(-req_i.a) : 48'(req_i.a);
        b_q    <= req_i.b[31] ? 32'(-req_i.b) : 32'(req_i.b);
        neg_q  <= req_i.a[47] ^ req_i.b[31];
        sh38_q <= req_i.sh38;
        sat_q  <= req_i.sat;
      end else if (busy_q) begin
        if (cnt_q != 2'd3) begin
          acc_q <= acc_q + ({32'd0, pp} << {cnt_q, 4'b0});
          cnt_q <= cnt_q + 2'd1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// File: rtl/ocpp_core.sv
// Sequencer for square root, angle, polynomial, division and affine steps of one projection.
`timescale 1ns / 1ps
`default_nettype none
module ocpp_core import ocpp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  in_req_t             req_i,
  input  cfg_t                cfg_i,
  output logic [TERM_W-1:0]   coef_idx_o,
  input  logic signed [47:0]  coef_i,
  output logic                idle_o,
  output logic                res_valid_o,
  output out_rsp_t            res_o,
  input  logic                res_take_i,
  output mul_req_t            mul_req_o,
  input  logic                mul_done_i,
  input  logic signed [48:0]  mul_res_i
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SQ_A   = 10'b00_0000_0010,
    S_SQ_B   = 10'b00_0000_0100,
    S_SQRT   = 10'b00_0000_1000,
    S_NORM   = 10'b00_0001_0000,
    S_CORDIC = 10'b00_0010_0000,
    S_HORNER = 10'b00_0100_0000,
    S_DIV    = 10'b00_1000_0000,
    S_MUL    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] o;
    if (v > 51'sh7FFF_FFFF) begin
      o = 32'sh7FFF_FFFF;
    end else if (v < -51'sh8000_0000) begin
      o = 32'sh8000_0000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  state_e state_q, state_d;
  logic [31:0] mx_q, mx_d, my_q, my_d;
  logic sx_q, sx_d, sy_q, sy_d;
  logic signed [31:0] z_q, z_d;
  logic [63:0] sqn_q, sqn_d, sqr_q, sqr_d;
  logic [TCNT_W-1:0] cnt_q, cnt_d;
  logic [31:0] r_q, r_d;
  logic [32:0] m_q, m_d;
  logic signed [37:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [33:0] ang_q, ang_d;
  logic signed [47:0] rho_q, rho_d;
  logic [31:0] rem_q, rem_d;
  logic [30:0] nl_q, nl_d, qt_q, qt_d;
  logic dsel_q, dsel_d;
  logic signed [31:0] ratx_q, ratx_d, raty_q, raty_d;
  logic mwait_q, mwait_d;
  logic signed [48:0] px_q, px_d, py_q, py_d, tu_q, tu_d, tu2_q, tu2_d;
  out_rsp_t res_q, res_d;

  logic [31:0] sq_m;
  logic [63:0] sq_p, sq_bit, sq_t, sqr_nx, sqn_nx;
  logic sq_ge;
  logic [31:0] z_mag;
  logic [32:0] m_init;
  logic [4:0] csh;
  logic signed [37:0] dx, dy;
  logic signed [31:0] theta;
  logic [TCNT_W-1:0] n_terms;
  logic signed [49:0] hsum;
  logic signed [47:0] hsat;
  logic [61:0] num_x, num_y;
  logic [32:0] d_t;
  logic d_ge;
  logic [30:0] q_fin;
  logic signed [31:0] ratio;
  logic signed [50:0] u_sum, v_sum;

  assign sq_m   = (state_q == S_SQ_A) ? mx_q : my_q;
  assign sq_p   = sq_m * sq_m;
  assign sq_bit = 64'd1 << (6'd62 - {cnt_q[4:0], 1'b0});
  assign sq_t   = sqr_q + sq_bit;
  assign sq_ge  = sqn_q >= sq_t;
  assign sqr_nx = sq_ge ? ((sqr_q >> 1) + sq_bit) : (sqr_q >> 1);
  assign sqn_nx = sq_ge ? (sqn_q - sq_t) : sqn_q;
  assign z_mag  = z_q[31] ? 32'(-z_q) : 32'(z_q);
  assign m_init = (sqr_nx[31:0] > z_mag) ? {1'b0, sqr_nx[31:0]} : {1'b0, z_mag};

  assign csh   = cnt_q[4:0];
  assign dx    = vy_q >>> csh;
  assign dy    = vx_q >>> csh;
  assign theta = ang_q[31:0];

  assign n_terms = ({1'b0, cfg_i.poly_terms} > TCNT_W'(MAX_TERMS)) ?
                   TCNT_W'(MAX_TERMS) : {1'b0, cfg_i.poly_terms};
  assign coef_idx_o = cnt_q[TERM_W-1:0];
  assign hsum = 50'(mul_res_i) + 50'(coef_i);
  assign hsat = (hsum > 50'(HI48)) ? HI48 : ((hsum < 50'(LO48)) ? LO48 : hsum[47:0]);

  assign num_x = {mx_q, 30'd0} + {31'd0, r_q[31:1]};
  assign num_y = {my_q, 30'd0} + {31'd0, r_q[31:1]};
  assign d_t   = {rem_q, nl_q[30]};
  assign d_ge  = d_t >= {1'b0, r_q};
  assign q_fin = {qt_q[29:0], d_ge};
  assign ratio = (dsel_q ? sy_q : sx_q) ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});

  assign u_sum = 51'(tu_q) + 51'(tu2_q) + $signed({23'd0, cfg_i.center_x});
  assign v_sum = 51'(mul_res_i) + 51'(py_q) + $signed({23'd0, cfg_i.center_y});

  always_comb begin
    mul_req_o.start = !mwait_q &&
                      (((state_q == S_HORNER) && (cnt_q != n_terms)) || (state_q == S_MUL));
    mul_req_o.a     = rho_q;
    mul_req_o.b     = theta;
    mul_req_o.sh38  = 1'b0;
    mul_req_o.sat   = (state_q == S_HORNER);
    if (state_q == S_MUL) begin
      case (cnt_q)
        TCNT_W'(0): begin
          mul_req_o.b    = ratx_q;
          mul_req_o.sh38 = 1'b1;
        end
        TCNT_W'(1): begin
          mul_req_o.b    = raty_q;
          mul_req_o.sh38 = 1'b1;
        end
        TCNT_W'(2): begin
          mul_req_o.a = px_q[47:0];
          mul_req_o.b = cfg_i.affine_c;
        end
        TCNT_W'(3): begin
          mul_req_o.a = py_q[47:0];
          mul_req_o.b = cfg_i.affine_d;
        end
        default: begin
          mul_req_o.a = px_q[47:0];
          mul_req_o.b = cfg_i.affine_e;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    mx_d = mx_q; my_d = my_q; sx_d = sx_q; sy_d = sy_q; z_d = z_q;
    sqn_d = sqn_q; sqr_d = sqr_q; cnt_d = cnt_q; r_d = r_q; m_d = m_q;
    vx_d = vx_q; vy_d = vy_q; ang_d = ang_q; rho_d = rho_q;
    rem_d = rem_q; nl_d = nl_q; qt_d = qt_q; dsel_d = dsel_q;
    ratx_d = ratx_q; raty_d = raty_q; mwait_d = mwait_q;
    px_d = px_q; py_d = py_q; tu_d = tu_q; tu2_d = tu2_q; res_d = res_q;
    if (mul_req_o.start) begin
      mwait_d = 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mx_d = req_i.point_x[31] ? 32'(-req_i.point_x) : 32'(req_i.point_x);
          my_d = req_i.point_y[31] ? 32'(-req_i.point_y) : 32'(req_i.point_y);
          sx_d = req_i.point_x[31];
          sy_d = req_i.point_y[31];
          z_d  = req_i.point_z;
          if ((req_i.point_x == 32'sd0) && (req_i.point_y == 32'sd0)) begin
            res_d.pixel_u = $signed({4'd0, cfg_i.center_x});
            res_d.pixel_v = $signed({4'd0, cfg_i.center_y});
            res_d.on_axis = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_SQ_A;
          end
        end
      end
      S_SQ_A: begin
        sqn_d = sq_p;
        state_d = S_SQ_B;
      end
      S_SQ_B: begin
        sqn_d = sqn_q + sq_p;
        sqr_d = '0;
        cnt_d = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        sqn_d = sqn_nx;
        sqr_d = sqr_nx;
        cnt_d = cnt_q + TCNT_W'(1);
        if (cnt_q == TCNT_W'(31)) begin
          r_d  = sqr_nx[31:0];
          m_d  = m_init;
          vx_d = $signed({6'd0, sqr_nx[31:0]});
          vy_d = 38'(z_q);
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (!m_q[32]) begin
          m_d  = m_q << 1;
          vx_d = vx_q <<< 1;
          vy_d = vy_q <<< 1;
        end else begin
          cnt_d = '0;
          ang_d = '0;
          state_d = S_CORDIC;
        end
      end
      S_CORDIC: begin
        if (!vy_q[37]) begin
          vx_d  = vx_q + dx;
          vy_d  = vy_q - dy;
          ang_d = ang_q + 34'(atan_q30(csh));
        end else begin
          vx_d  = vx_q - dx;
          vy_d  = vy_q + dy;
          ang_d = ang_q - 34'(atan_q30(csh));
        end
        cnt_d = cnt_q + TCNT_W'(1);
        if (cnt_q == TCNT_W'(30)) begin
          cnt_d = '0;
          rho_d = '0;
          state_d = S_HORNER;
        end
      end
      S_HORNER: begin
        if (cnt_q == n_terms) begin
          rem_d  = {1'b0, num_x[61:31]};
          nl_d   = num_x[30:0];
          dsel_d = 1'b0;
          cnt_d  = '0;
          state_d = S_DIV;
        end else if (mul_done_i) begin
          rho_d   = hsat;
          cnt_d   = cnt_q + TCNT_W'(1);
          mwait_d = 1'b0;
        end
      end
      S_DIV: begin
        rem_d = d_ge ? 32'(d_t - {1'b0, r_q}) : d_t[31:0];
        nl_d  = nl_q << 1;
        qt_d  = q_fin;
        cnt_d = cnt_q + TCNT_W'(1);
        if (cnt_q == TCNT_W'(30)) begin
          cnt_d = '0;
          if (!dsel_q) begin
            ratx_d = ratio;
            rem_d  = {1'b0, num_y[61:31]};
            nl_d   = num_y[30:0];
            dsel_d = 1'b1;
          end else begin
            raty_d = ratio;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_done_i) begin
          mwait_d = 1'b0;
          cnt_d = cnt_q + TCNT_W'(1);
          case (cnt_q)
            TCNT_W'(0): px_d = mul_res_i;
            TCNT_W'(1): py_d = mul_res_i;
            TCNT_W'(2): tu_d = mul_res_i;
            TCNT_W'(3): tu2_d = mul_res_i;
            default: begin
              res_d.pixel_u = sat32(u_sum);
              res_d.pixel_v = sat32(v_sum);
              res_d.on_axis = 1'b0;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mwait_q <= 1'b0;
      dsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mwait_q <= mwait_d;
      dsel_q  <= dsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d; my_q <= my_d; sx_q <= sx_d; sy_q <= sy_d; z_q <= z_d;
    sqn_q <= sqn_d; sqr_q <= sqr_d; r_q <= r_d; m_q <= m_d;
    vx_q <= vx_d; vy_q <= vy_d; ang_q <= ang_d; rho_q <= rho_d;
    rem_q <= rem_d; nl_q <= nl_d; qt_q <= qt_d;
    ratx_q <= ratx_d; raty_q <= raty_d;
    px_q <= px_d; py_q <= py_d; tu_q <= tu_d; tu2_q <= tu2_d; res_q <= res_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule
`default_nettype wire

// File: rtl/omni_camera_point_projection_top.sv
// Top level of the omnidirectional camera point projection block.
// The input channel takes one request at a time. A request with func 0 loads one
// polynomial coefficient into the table and gives no result. A request with
// func 1 projects a camera-frame point and gives one result holding pixel_u,
// pixel_v and on_axis. A point on the optical axis skips the computation. For any
// other point the work is a 32-step square root, one to 32 normalising shifts,
// 31 angle steps, two 31-step divisions and the shared multiplier, which forms
// one product for each polynomial term in use and the five scaling products.
// The block accepts no new request while a point is in work. The result sits in
// an output register; a new request is taken while it waits, but the next
// projection holds its result until the receiver takes the previous one.
// Configuration is written through the write port while idle; the user must keep
// to this, as the block itself does not enforce it. Reset sets the centre to zero,
// the affine stretch to one and clears the term count; the coefficient table
// holds no defined value until loaded.
`timescale 1ns / 1ps
`default_nettype none
module omni_camera_point_projection_top import ocpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_rsp_t    out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t cfg_q;
  logic signed [47:0] coef_q [MAX_TERMS];
  logic out_valid_q;
  out_rsp_t out_q;

  logic core_idle, core_valid, take, accept;
  out_rsp_t core_res;
  logic [TERM_W-1:0] coef_idx;
  mul_req_t mul_req;
  logic mul_done;
  logic signed [48:0] mul_res;

  assign in_ready_o = core_idle;
  assign accept     = in_valid_i && core_idle;
  assign take       = core_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x   <= '0;
      cfg_q.center_y   <= '0;
      cfg_q.affine_c   <= AFFINE_C_RESET;
      cfg_q.affine_d   <= '0;
      cfg_q.affine_e   <= '0;
      cfg_q.poly_terms <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X:   cfg_q.center_x   <= cfg_data_i[27:0];
        CFG_CENTER_Y:   cfg_q.center_y   <= cfg_data_i[27:0];
        CFG_AFFINE_C:   cfg_q.affine_c   <= $signed(cfg_data_i);
        CFG_AFFINE_D:   cfg_q.affine_d   <= $signed(cfg_data_i);
        CFG_AFFINE_E:   cfg_q.affine_e   <= $signed(cfg_data_i);
        CFG_POLY_TERMS: cfg_q.poly_terms <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_req_i.func == FUNC_LOAD) && (32'(in_req_i.coef_index) < MAX_TERMS)) begin
      coef_q[TERM_W'(in_req_i.coef_index)] <= in_req_i.coef_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  ocpp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && (in_req_i.func == FUNC_PROJECT)),
    .req_i       (in_req_i),
    .cfg_i       (cfg_q),
    .coef_idx_o  (coef_idx),
    .coef_i      (coef_q[coef_idx]),
    .idle_o      (core_idle),
    .res_valid_o (core_valid),
    .res_o       (core_res),
    .res_take_i  (take),
    .mul_req_o   (mul_req),
    .mul_done_i  (mul_done),
    .mul_res_i   (mul_res)
  );

  ocpp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

endmodule
`default_nettype wire
